/* hw/rtl/unicode_charset_transcoder_top_assert.svh */
// assertion macros for the transcoder checker
`ifndef UNICODE_CHARSET_TRANSCODER_TOP_ASSERT_SVH
`define UNICODE_CHARSET_TRANSCODER_TOP_ASSERT_SVH

// implication checked at every clock edge outside reset
`define UCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define UCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/uct_pkg.sv */
// ---------------------------------------------------------------------------
// uct_pkg
// shared types, encoding codes and status codes of the charset transcoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uct_pkg;

    localparam logic [2:0] ENC_LATIN1  = 3'd0;
    localparam logic [2:0] ENC_ASCII   = 3'd1;
    localparam logic [2:0] ENC_UTF16LE = 3'd2;
    localparam logic [2:0] ENC_UTF16BE = 3'd3;
    localparam logic [2:0] ENC_UCS4LE  = 3'd4;
    localparam logic [2:0] ENC_UCS4BE  = 3'd5;
    localparam logic [2:0] ENC_UTF8    = 3'd6;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_ILL   = 2'd1;
    localparam logic [1:0] ST_INCMP = 2'd2;

    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_TGT = 1'b1;

    localparam int MaxOut = 8;

    // result of one input byte, bytes in emission order
    typedef struct packed {
        logic [3:0]                cnt;
        logic [MaxOut-1:0][7:0]    bytes;
        logic [1:0]                status;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/uct_core.sv */
// ---------------------------------------------------------------------------
// uct_core
// decodes one source byte against held state and encodes into target bytes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uct_core
    import uct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_clear,
    input  wire logic [2:0] i_src,
    input  wire logic [2:0] i_tgt,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eob,
    output t_res            o_res
);

    logic [3:0][7:0] r_pend;
    logic [2:0]      r_pcnt;
    logic [2:0]      r_u8st;
    logic [20:0]     r_cp;

    logic [3:0][7:0] n_pend;
    logic [2:0]      n_pcnt;
    logic [2:0]      n_u8st;
    logic [20:0]     n_cp;

    // encode one character into a byte list; returns ok flag
    function automatic logic enc(input logic [2:0] tgt, input logic [31:0] c,
                                 output logic [3:0] len, output logic [5:0][7:0] b);
        logic [31:0] hs;
        logic [15:0] h, l;
        logic [2:0]  k;
        logic [7:0]  lead;
        logic        ok;
        ok = 1'b1;
        len = 4'd0;
        b = '0;
        hs = 32'h0000d7c0 + (c >> 10);
        h = hs[15:0];
        l = 16'hdc00 + {6'd0, c[9:0]};
        k = 3'd0;
        lead = 8'd0;
        unique case (tgt) inside
            ENC_LATIN1: begin
                ok = c < 32'h100; len = 4'd1; b[0] = c[7:0];
            end
            ENC_ASCII: begin
                ok = c < 32'h80; len = 4'd1; b[0] = c[7:0];
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (c < 32'h10000) begin
                    len = 4'd2;
                    b[0] = (tgt == ENC_UTF16BE) ? c[15:8] : c[7:0];
                    b[1] = (tgt == ENC_UTF16BE) ? c[7:0] : c[15:8];
                end else if (c >= 32'h110000) begin
                    ok = 1'b0;
                end else begin
                    len = 4'd4;
                    b[0] = (tgt == ENC_UTF16BE) ? h[15:8] : h[7:0];
                    b[1] = (tgt == ENC_UTF16BE) ? h[7:0] : h[15:8];
                    b[2] = (tgt == ENC_UTF16BE) ? l[15:8] : l[7:0];
                    b[3] = (tgt == ENC_UTF16BE) ? l[7:0] : l[15:8];
                end
            end
            ENC_UCS4LE: begin
                len = 4'd4;
                b[0] = c[7:0]; b[1] = c[15:8]; b[2] = c[23:16]; b[3] = c[31:24];
            end
            ENC_UCS4BE: begin
                len = 4'd4;
                b[0] = c[31:24]; b[1] = c[23:16]; b[2] = c[15:8]; b[3] = c[7:0];
            end
            ENC_UTF8: begin
                if (c < 32'h80)            k = 3'd1;
                else if (c < 32'h800)      k = 3'd2;
                else if (c < 32'h10000)    k = 3'd3;
                else if (c < 32'h200000)   k = 3'd4;
                else if (c < 32'h4000000)  k = 3'd5;
                else if (c < 32'h80000000) k = 3'd6;
                else                       k = 3'd0;
                ok = (k != 3'd0);
                len = {1'b0, k};
                lead = 8'(16'hff00 >> k);
                unique case (k)
                    3'd1: b[0] = c[7:0];
                    3'd2: begin
                        b[0] = lead | {3'd0, c[10:6]};
                        b[1] = {2'b10, c[5:0]};
                    end
                    3'd3: begin
                        b[0] = lead | {4'd0, c[15:12]};
                        b[1] = {2'b10, c[11:6]}; b[2] = {2'b10, c[5:0]};
                    end
                    3'd4: begin
                        b[0] = lead | {5'd0, c[20:18]};
                        b[1] = {2'b10, c[17:12]}; b[2] = {2'b10, c[11:6]};
                        b[3] = {2'b10, c[5:0]};
                    end
                    3'd5: begin
                        b[0] = lead | {6'd0, c[25:24]};
                        b[1] = {2'b10, c[23:18]}; b[2] = {2'b10, c[17:12]};
                        b[3] = {2'b10, c[11:6]}; b[4] = {2'b10, c[5:0]};
                    end
                    3'd6: begin
                        b[0] = lead | {7'd0, c[30]};
                        b[1] = {2'b10, c[29:24]}; b[2] = {2'b10, c[23:18]};
                        b[3] = {2'b10, c[17:12]}; b[4] = {2'b10, c[11:6]};
                        b[5] = {2'b10, c[5:0]};
                    end
                    default: len = 4'd0;
                endcase
            end
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    logic            have1, have2, ok1, ok2, bad, pend_after;
    logic [31:0]     c1, c2;
    logic [3:0]      l1, l2;
    logic [5:0][7:0] b1, b2;
    logic [3:0][7:0] pb;
    logic [15:0]     u1, u2;
    logic [2:0]      pc1;
    logic [2:0]      lo_sel;
    logic [7:0]      lo, hi;
    logic [20:0]     cpn;
    logic            be;
    logic [MaxOut-1:0][7:0] obytes;
    logic [3:0]      ocnt;

    always_comb begin
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        n_u8st = r_u8st;
        n_cp   = r_cp;
        have1 = 1'b0; have2 = 1'b0; bad = 1'b0;
        c1 = 32'd0; c2 = 32'd0;
        pb = r_pend;
        pb[r_pcnt[1:0]] = i_byte;
        pc1 = r_pcnt + 3'd1;
        be = (i_src == ENC_UTF16BE);
        u1 = be ? {pb[0], pb[1]} : {pb[1], pb[0]};
        u2 = be ? {pb[2], pb[3]} : {pb[3], pb[2]};
        lo_sel = 3'd0;
        lo = 8'h80; hi = 8'hbf;
        cpn = {r_cp[14:0], i_byte[5:0]};
        unique case (i_src) inside
            ENC_LATIN1: begin
                have1 = 1'b1; c1 = {24'd0, i_byte};
            end
            ENC_ASCII: begin
                bad = i_byte[7]; have1 = !i_byte[7]; c1 = {24'd0, i_byte};
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                n_pend = pb;
                n_pcnt = pc1;
                if (pc1 == 3'd2) begin
                    if (u1[15:10] != 6'b110110) begin
                        have1 = 1'b1; c1 = {16'd0, u1}; n_pcnt = 3'd0;
                    end
                end else if (pc1 == 3'd4) begin
                    if (u2[15:10] == 6'b110111) begin
                        have1 = 1'b1;
                        c1 = 32'h10000 + {12'd0, u1[9:0], u2[9:0]};
                        n_pcnt = 3'd0;
                    end else begin
                        have1 = 1'b1; c1 = {16'd0, u1};
                        n_pend[0] = pb[2]; n_pend[1] = pb[3];
                        n_pcnt = 3'd2;
                        if (u2[15:10] != 6'b110110) begin
                            have2 = 1'b1; c2 = {16'd0, u2}; n_pcnt = 3'd0;
                        end
                    end
                end
            end
            ENC_UCS4LE, ENC_UCS4BE: begin
                n_pend = pb;
                n_pcnt = pc1;
                if (pc1 >= 3'd4) begin
                    have1 = 1'b1; n_pcnt = 3'd0;
                    c1 = (i_src == ENC_UCS4LE) ? {pb[3], pb[2], pb[1], pb[0]}
                                               : {pb[0], pb[1], pb[2], pb[3]};
                end
            end
            ENC_UTF8: begin
                if (r_u8st == 3'd0) begin
                    if (!i_byte[7]) begin
                        have1 = 1'b1; c1 = {24'd0, i_byte};
                    end else if (i_byte >= 8'hc2 && i_byte <= 8'hdf) begin
                        n_u8st = 3'd1; n_cp = {16'd0, i_byte[4:0]};
                    end else if (i_byte >= 8'he0 && i_byte <= 8'hef) begin
                        n_u8st = (i_byte == 8'he0) ? 3'd3 : ((i_byte == 8'hed) ? 3'd4 : 3'd2);
                        n_cp = {17'd0, i_byte[3:0]};
                    end else if (i_byte >= 8'hf0 && i_byte <= 8'hf4) begin
                        n_u8st = (i_byte == 8'hf0) ? 3'd6 : ((i_byte == 8'hf4) ? 3'd7 : 3'd5);
                        n_cp = {18'd0, i_byte[2:0]};
                    end else begin
                        bad = 1'b1;
                    end
                end else begin
                    case (r_u8st)
                        3'd1: lo_sel = 3'd0;
                        3'd2: lo_sel = 3'd1;
                        3'd3: begin lo_sel = 3'd1; lo = 8'ha0; end
                        3'd4: begin lo_sel = 3'd1; hi = 8'h9f; end
                        3'd5: lo_sel = 3'd2;
                        3'd6: begin lo_sel = 3'd2; lo = 8'h90; end
                        default: begin lo_sel = 3'd2; hi = 8'h8f; end
                    endcase
                    if (i_byte < lo || i_byte > hi) begin
                        bad = 1'b1;
                    end else begin
                        n_cp = cpn;
                        n_u8st = lo_sel;
                        if (lo_sel == 3'd0) begin
                            have1 = 1'b1; c1 = {11'd0, cpn};
                        end
                    end
                end
            end
            default: bad = 1'b1;
        endcase
    end

    always_comb begin
        ok1 = enc(i_tgt, c1, l1, b1);
        ok2 = enc(i_tgt, c2, l2, b2);
        obytes = '0;
        for (int i = 0; i < 6; i++) obytes[i] = b1[i];
        if (have2) begin
            for (int i = 0; i < 4; i++) obytes[3'(i) + l1[2:0]] = b2[i];
        end
        ocnt = (have1 ? l1 : 4'd0) + (have2 ? l2 : 4'd0);
        pend_after = (n_pcnt != 3'd0) || (n_u8st != 3'd0);
        o_res.bytes  = obytes;
        o_res.cnt    = ocnt;
        o_res.status = ST_DATA;
        if (i_src == i_tgt) begin
            o_res.cnt = 4'd1;
            o_res.bytes = '0;
            o_res.bytes[0] = i_byte;
        end else if (bad || (have1 && !ok1) || (have2 && !ok2)) begin
            o_res.cnt = 4'd1; o_res.bytes = '0; o_res.status = ST_ILL;
        end else if (i_eob && pend_after) begin
            o_res.bytes[ocnt[2:0]] = 8'd0;
            o_res.cnt = ocnt + 4'd1;
            o_res.status = ST_INCMP;
        end
    end

    logic drop;
    assign drop = (i_src != i_tgt) && (o_res.status != ST_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 3'd0;
            r_u8st <= 3'd0;
            r_cp   <= '0;
        end else if (i_clear) begin
            r_pcnt <= 3'd0;
            r_u8st <= 3'd0;
            r_cp   <= '0;
        end else if (i_step && i_src != i_tgt) begin
            r_pcnt <= drop ? 3'd0 : n_pcnt;
            r_u8st <= drop ? 3'd0 : n_u8st;
            r_cp   <= drop ? '0 : n_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/uct_outq.sv */
// ---------------------------------------------------------------------------
// uct_outq
// holds the bytes of one result and drains them one per transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uct_outq
    import uct_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  t_res       i_res,
    output logic       o_free,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic [1:0] o_status,
    input  wire logic  i_ready
);

    t_res       r_res;
    logic [3:0] r_idx;
    logic       r_valid;
    logic       done;

    assign o_valid  = r_valid;
    assign o_byte   = r_res.bytes[r_idx[2:0]];
    assign o_last   = (r_idx + 4'd1 == r_res.cnt);
    assign o_status = o_last ? r_res.status : ST_DATA;
    assign done     = r_valid && i_ready && o_last;
    assign o_free   = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else if (i_load && i_res.cnt != 4'd0) begin
            r_valid <= 1'b1;
            r_idx   <= 4'd0;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/unicode_charset_transcoder_top.sv */
// ---------------------------------------------------------------------------
// unicode_charset_transcoder_top
// byte-stream transcoder between latin1, ascii, utf-16, ucs-4 and utf-8
// ---------------------------------------------------------------------------
// One source byte is taken per cycle while the output is free; its character
// is decoded and re-encoded in the same cycle into a result register of up to
// eight bytes, which then drains one byte per output transfer. A byte giving
// k output bytes occupies the output for k transfers, and the next input is
// taken in the cycle the last one transfers. Bytes that complete no character
// pass at one per cycle. Configuration writes clear any partial character.
`timescale 1ns / 1ps
`default_nettype none

module unicode_charset_transcoder_top
    import uct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // end_of_buffer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte
    output logic             m_axis_tlast,   // run_last
    output logic [1:0]       m_axis_tuser,   // status
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [2:0]  i_cfg_data
);

    logic [2:0] r_src, r_tgt;
    logic       step, free, cfg_wr;
    t_res       res;

    assign s_axis_tready = free;
    assign step          = s_axis_tvalid && free;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= ENC_UTF8;
            r_tgt <= ENC_UTF16LE;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SRC: r_src <= i_cfg_data;
                CFG_TGT: r_tgt <= i_cfg_data;
                default: r_src <= r_src;
            endcase
        end
    end

    uct_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_clear (cfg_wr),
        .i_src   (r_src),
        .i_tgt   (r_tgt),
        .i_byte  (s_axis_tdata),
        .i_eob   (s_axis_tlast),
        .o_res   (res)
    );

    uct_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_res    (res),
        .o_free   (free),
        .o_valid  (m_axis_tvalid),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_status (m_axis_tuser),
        .i_ready  (m_axis_tready)
    );

endmodule

`default_nettype wire

/* hw/rtl/uct_checker.sv */
// ---------------------------------------------------------------------------
// uct_checker
// port-level checks of the transcoder output stream
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "unicode_charset_transcoder_top_assert.svh"

module uct_checker
    import uct_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic       m_axis_tlast,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser
);

    `UCT_ASSERT_IMP(a_err_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_DATA,
        m_axis_tlast && m_axis_tdata == 8'd0, "error result not final or nonzero")
    `UCT_ASSERT_IMP(a_status_rng, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tuser != 2'd3, "bad status code")
    `UCT_ASSERT_IMP(a_no_take, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast,
        !s_axis_tready, "input taken mid result")
    `UCT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

endmodule

bind unicode_charset_transcoder_top uct_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
